>>> rtl/asms_pkg.sv
// shared constants, types and tables for the annular sector membership block
package asms_pkg;

  // configuration of the datapath
  localparam int CORDIC_STAGES = 16;
  localparam int COORD_WIDTH   = 16;

  // widths derived from the coordinate width
  localparam int XW   = COORD_WIDTH + 10;                // cordic x/y, signed
  localparam int ZW   = 25;                              // angle accumulator, signed
  localparam int PW   = XW - 1 + 16;                     // radius product
  localparam int RW   = COORD_WIDTH + 1;                 // radius, unsigned integer
  localparam int DW   = (RW + 1 > 17) ? RW + 1 : 17;     // radial distance math
  localparam int AW   = 15;                              // angle in 1/64 degree
  localparam int NUMW = 17;                              // divider numerator
  localparam int DENW = 16;                              // divider denominator
  localparam int QW   = 15;                              // quotient bits below 1.0

  // pipeline depths
  localparam int CORDIC_LAT = CORDIC_STAGES + 3;
  localparam int DIV_LAT    = QW + 1;
  localparam int PIPE_DEPTH = CORDIC_LAT + 1 + DIV_LAT;

  // angle and gain constants
  localparam logic [AW-1:0]        FULL_TURN     = 15'd23040;
  localparam logic signed [ZW-1:0] ACC_HALF_TURN = 25'sd2949120;
  localparam logic signed [ZW-1:0] ACC_FULL_TURN = 25'sd5898240;
  localparam logic [15:0]          INV_GAIN_Q16  = 16'd39798;
  localparam logic [15:0]          ONE_Q15       = 16'd32768;

  // configuration register indexes
  localparam logic [1:0] REG_MIN_RADIUS  = 2'd0;
  localparam logic [1:0] REG_MAX_RADIUS  = 2'd1;
  localparam logic [1:0] REG_START_ANGLE = 2'd2;
  localparam logic [1:0] REG_END_ANGLE   = 2'd3;

  // arctangent of 2^-i in 1/16384 degree
  function automatic logic signed [ZW-1:0] atan_f(input int i);
    logic signed [ZW-1:0] v;
    begin
      unique case (i)
        0:  v = 25'sd737280;
        1:  v = 25'sd435242;
        2:  v = 25'sd229970;
        3:  v = 25'sd116736;
        4:  v = 25'sd58595;
        5:  v = 25'sd29326;
        6:  v = 25'sd14667;
        7:  v = 25'sd7334;
        8:  v = 25'sd3667;
        9:  v = 25'sd1833;
        10: v = 25'sd917;
        11: v = 25'sd458;
        12: v = 25'sd229;
        13: v = 25'sd115;
        14: v = 25'sd57;
        15: v = 25'sd29;
        16: v = 25'sd14;
        17: v = 25'sd7;
        18: v = 25'sd4;
        19: v = 25'sd2;
        20: v = 25'sd1;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage

>>> rtl/annular_sector_membership_strength.sv
// top level: annular sector membership and strength of a point stream
// One point is taken per clock cycle while no output stall holds the pipeline; its result
// passes through the cordic (fold, 16 rotation stages, gain multiply, rounding), the window
// test register, the two radial and angular dividers working one quotient bit per stage,
// and the output register. A stall on the output freezes the whole pipeline; points
// keep entering whenever the output register is empty or being taken.
module annular_sector_membership_strength (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [asms_pkg::COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [asms_pkg::COORD_WIDTH-1:0] coord_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   inside_res_o,
  output logic [15:0]                            strength_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [3:0]                             paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int D = asms_pkg::PIPE_DEPTH;

  // configuration registers
  logic [15:0]             min_radius_q, max_radius_q;
  logic [asms_pkg::AW-1:0] start_angle_q, end_angle_q;
  logic                    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_radius_q  <= '0;
      max_radius_q  <= 16'hFFFF;
      start_angle_q <= '0;
      end_angle_q   <= asms_pkg::FULL_TURN;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        asms_pkg::REG_MIN_RADIUS:  min_radius_q  <= pwdata[15:0];
        asms_pkg::REG_MAX_RADIUS:  max_radius_q  <= pwdata[15:0];
        asms_pkg::REG_START_ANGLE: start_angle_q <= pwdata[asms_pkg::AW-1:0];
        asms_pkg::REG_END_ANGLE:   end_angle_q   <= pwdata[asms_pkg::AW-1:0];
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      asms_pkg::REG_MIN_RADIUS:  prdata = {16'd0, min_radius_q};
      asms_pkg::REG_MAX_RADIUS:  prdata = {16'd0, max_radius_q};
      asms_pkg::REG_START_ANGLE: prdata = {17'd0, start_angle_q};
      asms_pkg::REG_END_ANGLE:   prdata = {17'd0, end_angle_q};
    endcase
  end

  // global pipeline advance
  logic out_valid_q;
  logic en;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // valid bits travel alongside the data
  logic [D-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[D-2:0], in_valid_i};
      out_valid_q <= vld_q[D-1];
    end
  end

  // radius and angle
  logic [asms_pkg::AW-1:0] ang;
  logic [asms_pkg::RW-1:0] rad;

  asms_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (coord_x_i),
    .y_i   (coord_y_i),
    .ang_o (ang),
    .rad_o (rad)
  );

  // window tests and distances from the sector centre
  logic [asms_pkg::AW-1:0] s_ang, e_ang;
  logic [asms_pkg::DW-1:0] r_ext, rsum, r2, rdist;
  logic [asms_pkg::DW-1:0] mn_ext, mx_ext;
  logic                    rin, ain, nowrap;
  logic [asms_pkg::AW-1:0] arange;
  logic [15:0]             c2, a2, ad, adf, full2;
  logic [16:0]             c2w;

  always_comb begin
    s_ang  = (start_angle_q > asms_pkg::FULL_TURN) ? asms_pkg::FULL_TURN : start_angle_q;
    e_ang  = (end_angle_q > asms_pkg::FULL_TURN) ? asms_pkg::FULL_TURN : end_angle_q;
    nowrap = s_ang <= e_ang;
    full2  = {asms_pkg::FULL_TURN, 1'b0};

    r_ext  = asms_pkg::DW'(rad);
    mn_ext = asms_pkg::DW'(min_radius_q);
    mx_ext = asms_pkg::DW'(max_radius_q);
    rin    = (r_ext >= mn_ext) && (r_ext <= mx_ext);
    ain    = nowrap ? (ang >= s_ang && ang <= e_ang) : (ang >= s_ang || ang <= e_ang);

    rsum   = mn_ext + mx_ext;
    r2     = r_ext << 1;
    rdist  = (r2 >= rsum) ? r2 - rsum : rsum - r2;

    // wrapped window centre lies half a turn across zero
    c2w = 17'(s_ang) + 17'(e_ang);
    if (nowrap) begin
      arange = e_ang - s_ang;
      c2     = c2w[15:0];
    end else begin
      arange = asms_pkg::FULL_TURN - s_ang + e_ang;
      c2w    = c2w + 17'(asms_pkg::FULL_TURN);
      c2     = (c2w >= 17'(full2)) ? 16'(c2w - 17'(full2)) : c2w[15:0];
    end
    a2  = {ang, 1'b0};
    ad  = (a2 >= c2) ? a2 - c2 : c2 - a2;
    adf = (ad > 16'(asms_pkg::FULL_TURN)) ? full2 - ad : ad;
  end

  logic [asms_pkg::NUMW-1:0] rnum_q, anum_q;
  logic [asms_pkg::DENW-1:0] rden_q, aden_q;
  logic [asms_pkg::DIV_LAT:0] ins_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rnum_q   <= rdist[asms_pkg::NUMW-1:0];
      rden_q   <= max_radius_q - min_radius_q;
      anum_q   <= asms_pkg::NUMW'(adf);
      aden_q   <= asms_pkg::DENW'(arange);
      ins_q    <= {ins_q[asms_pkg::DIV_LAT-1:0], rin && ain};
    end
  end

  // normalized radial and angular terms
  logic [15:0] tr, ta;

  asms_div u_div_rad (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (rnum_q),
    .den_i (rden_q),
    .quo_o (tr)
  );

  asms_div u_div_ang (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (anum_q),
    .den_i (aden_q),
    .quo_o (ta)
  );

  // strength and output register
  logic [16:0] tsum;
  logic [15:0] strength_d;
  logic        in_sector;
  assign in_sector  = ins_q[asms_pkg::DIV_LAT];
  assign tsum       = 17'(tr) + 17'(ta);
  assign strength_d = in_sector ? asms_pkg::ONE_Q15 - tsum[16:1] : '0;

  logic        inside_q;
  logic [15:0] strength_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_q   <= in_sector;
      strength_q <= strength_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;
  assign strength_o   = strength_q;

endmodule

>>> rtl/asms_cordic.sv
// pipelined vectoring cordic: radius and angle of a point
module asms_cordic (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [asms_pkg::COORD_WIDTH-1:0] x_i,
  input  logic signed [asms_pkg::COORD_WIDTH-1:0] y_i,
  output logic [asms_pkg::AW-1:0]                ang_o,
  output logic [asms_pkg::RW-1:0]                rad_o
);

  localparam int S = asms_pkg::CORDIC_STAGES;

  logic signed [asms_pkg::XW-1:0] x_q [0:S];
  logic signed [asms_pkg::XW-1:0] y_q [0:S];
  logic signed [asms_pkg::ZW-1:0] z_q [0:S];
  logic                           org_q [0:S];

  // fold into the right half plane and scale
  logic signed [asms_pkg::XW-1:0] xe, ye;
  logic                           neg;
  assign xe  = asms_pkg::XW'(x_i);
  assign ye  = asms_pkg::XW'(y_i);
  assign neg = x_i[asms_pkg::COORD_WIDTH-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= (neg ? -xe : xe) <<< 8;
      y_q[0]   <= (neg ? -ye : ye) <<< 8;
      z_q[0]   <= neg ? asms_pkg::ACC_HALF_TURN : '0;
      org_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  // one rotation per stage
  for (genvar k = 0; k < S; k++) begin : g_iter
    logic signed [asms_pkg::XW-1:0] xs, ys;
    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[k] > 0) begin
          x_q[k+1] <= x_q[k] + ys;
          y_q[k+1] <= y_q[k] - xs;
          z_q[k+1] <= z_q[k] + asms_pkg::atan_f(k);
        end else begin
          x_q[k+1] <= x_q[k] - ys;
          y_q[k+1] <= y_q[k] + xs;
          z_q[k+1] <= z_q[k] - asms_pkg::atan_f(k);
        end
        org_q[k+1] <= org_q[k];
      end
    end
  end

  // angle wrap and rounding to 1/64 degree
  logic signed [asms_pkg::ZW-1:0] zw;
  logic [asms_pkg::ZW-1:0]        asum;
  logic [asms_pkg::ZW-9:0]        afull;
  logic [asms_pkg::AW-1:0]        ang_d;
  always_comb begin
    priority if (z_q[S] < 0) begin
      zw = z_q[S] + asms_pkg::ACC_FULL_TURN;
    end else if (z_q[S] >= asms_pkg::ACC_FULL_TURN) begin
      zw = z_q[S] - asms_pkg::ACC_FULL_TURN;
    end else begin
      zw = z_q[S];
    end
    asum  = $unsigned(zw) + asms_pkg::ZW'(128);
    afull = asum[asms_pkg::ZW-1:8];
    if (org_q[S] || afull >= (asms_pkg::ZW-8)'(asms_pkg::FULL_TURN)) begin
      ang_d = '0;
    end else begin
      ang_d = afull[asms_pkg::AW-1:0];
    end
  end

  // gain correction product
  logic [asms_pkg::PW-1:0] prod_q;
  logic [asms_pkg::AW-1:0] ang1_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= asms_pkg::PW'($unsigned(x_q[S][asms_pkg::XW-2:0]))
              * asms_pkg::PW'(asms_pkg::INV_GAIN_Q16);
      ang1_q <= ang_d;
    end
  end

  // round the radius to an integer
  logic [asms_pkg::PW:0] rsum;
  assign rsum = {1'b0, prod_q} + (asms_pkg::PW+1)'(1 << 23);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_o <= rsum[24 +: asms_pkg::RW];
      ang_o <= ang1_q;
    end
  end

endmodule

>>> rtl/asms_div.sv
// pipelined restoring divider for a q0.15 ratio clamped to 1.0
module asms_div (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [asms_pkg::NUMW-1:0]   num_i,
  input  logic [asms_pkg::DENW-1:0]   den_i,
  output logic [15:0]                 quo_o
);

  localparam int N = asms_pkg::QW;

  logic [asms_pkg::DENW-1:0] rem_q [0:N];
  logic [asms_pkg::DENW-1:0] den_q [0:N];
  logic [N-1:0]              q_q   [0:N];
  logic                      sat_q [0:N];
  logic                      zero_q [0:N];

  // ratio of one or more saturates, zero range gives zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i[asms_pkg::DENW-1:0];
      den_q[0]  <= den_i;
      q_q[0]    <= '0;
      sat_q[0]  <= num_i >= asms_pkg::NUMW'(den_i);
      zero_q[0] <= den_i == '0;
    end
  end

  // one quotient bit per stage
  for (genvar j = 0; j < N; j++) begin : g_step
    logic [asms_pkg::DENW:0] r2;
    logic                    ge;
    assign r2 = {rem_q[j], 1'b0};
    assign ge = r2 >= {1'b0, den_q[j]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= ge ? asms_pkg::DENW'(r2 - {1'b0, den_q[j]})
                          : r2[asms_pkg::DENW-1:0];
        den_q[j+1]  <= den_q[j];
        q_q[j+1]    <= {q_q[j][N-2:0], ge};
        sat_q[j+1]  <= sat_q[j];
        zero_q[j+1] <= zero_q[j];
      end
    end
  end

  always_comb begin
    priority if (zero_q[N]) begin
      quo_o = '0;
    end else if (sat_q[N]) begin
      quo_o = asms_pkg::ONE_Q15;
    end else begin
      quo_o = {1'b0, q_q[N]};
    end
  end

endmodule

>>> rtl/asms_chk.sv
// port checker for the annular sector block and its bind
module asms_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        inside_res_o,
  input logic [15:0] strength_o
);

  // a held result keeps its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(strength_o) && $stable(inside_res_o))
    else $error("stalled result changed");

  // outside points carry no strength
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !inside_res_o |-> strength_o == 16'd0)
    else $error("strength nonzero outside sector");

  // strength never exceeds one
  a_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> strength_o <= 16'd32768)
    else $error("strength above one");

  // input side only stalls on a blocked output
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

endmodule

bind annular_sector_membership_strength asms_chk u_asms_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .inside_res_o (inside_res_o),
  .strength_o   (strength_o)
);

>>> sim/annular_sector_membership_strength_tb.sv
// testbench for the annular sector membership and strength block
`timescale 1ns / 100ps

module annular_sector_membership_strength_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 80;

  // one expected result
  typedef struct packed {
    logic        in_sector;
    logic [15:0] strength;
  } sector_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [15:0] coord_x_i = '0;
  logic signed [15:0] coord_y_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               inside_res_o;
  logic [15:0]        strength_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // predictor copy of the registers
  logic [15:0] min_rad_q;
  logic [15:0] max_rad_q;
  logic [14:0] start_ang_q;
  logic [14:0] end_ang_q;

  sector_result_t pending_results[$];
  int unsigned    mismatch_cnt;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    hold_off_cycles;
  int unsigned    idle_cycles;

  always #5 clk_i = ~clk_i;

  annular_sector_membership_strength u_top (.*);

  // arctangent table in 1/16384 degree
  function automatic longint arctan_step(int i);
    longint tab[21] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                        3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
    return (i < 21) ? tab[i] : 0;
  endfunction

  function automatic longint unsigned unit_ratio(longint unsigned num,
                                                 longint unsigned den);
    longint unsigned q;
    if (den == 0) return 0;
    q = (num * 32768) / den;
    return (q > 32768) ? 32768 : q;
  endfunction

  // membership and strength of one point
  function automatic sector_result_t sector_strength(logic signed [15:0] px,
                                                     logic signed [15:0] py);
    sector_result_t  res;
    longint          x, y, z, xs, ys;
    longint unsigned r, a, s, e, rsum, r2, rdist, tr, arange, c2, a2, ad, ta;
    logic            hit;
    x = px; y = py; z = 0; r = 0; a = 0;
    s = (start_ang_q > 23040) ? 23040 : start_ang_q;
    e = (end_ang_q > 23040) ? 23040 : end_ang_q;
    if (x != 0 || y != 0) begin
      if (x < 0) begin
        x = -x; y = -y; z = 2949120;
      end
      x = x * 256; y = y * 256;
      for (int i = 0; i < asms_pkg::CORDIC_STAGES; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (y > 0) begin
          x = x + ys; y = y - xs; z += arctan_step(i);
        end else begin
          x = x - ys; y = y + xs; z -= arctan_step(i);
        end
      end
      while (z < 0) z += 5898240;
      while (z >= 5898240) z -= 5898240;
      a = (longint'(z) + 128) >> 8;
      if (a >= 23040) a -= 23040;
      r = (longint'(x) * 39798 + (64'd1 << 23)) >> 24;
    end
    hit = (r >= min_rad_q) && (r <= max_rad_q);
    if (hit) hit = (s <= e) ? (a >= s && a <= e) : (a >= s || a <= e);
    res.in_sector = hit;
    res.strength = '0;
    if (hit) begin
      rsum = min_rad_q + max_rad_q;
      r2 = 2 * r;
      rdist = (r2 >= rsum) ? r2 - rsum : rsum - r2;
      tr = unit_ratio(rdist, max_rad_q - min_rad_q);
      a2 = 2 * a;
      if (s <= e) begin
        arange = e - s; c2 = s + e;
      end else begin
        arange = 23040 - s + e; c2 = (s + e + 23040) % 46080;
      end
      ad = (a2 >= c2) ? a2 - c2 : c2 - a2;
      if (ad > 23040) ad = 46080 - ad;
      ta = unit_ratio(ad, arange);
      res.strength = 16'(32768 - ((tr + ta) >> 1));
    end
    return res;
  endfunction

  // apb write, only while the pipeline is empty
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      asms_pkg::REG_MIN_RADIUS:  min_rad_q = value[15:0];
      asms_pkg::REG_MAX_RADIUS:  max_rad_q = value[15:0];
      asms_pkg::REG_START_ANGLE: start_ang_q = value[14:0];
      default:                   end_ang_q = value[14:0];
    endcase
  endtask

  task automatic set_sector(int mn, int mx, int st, int en);
    wait_drained();
    write_reg(asms_pkg::REG_MIN_RADIUS, mn);
    write_reg(asms_pkg::REG_MAX_RADIUS, mx);
    write_reg(asms_pkg::REG_START_ANGLE, st);
    write_reg(asms_pkg::REG_END_ANGLE, en);
  endtask

  // stop offering and wait for every expected result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // offer one point until the block takes it, valid stays up for the next one
  task automatic send_point(logic signed [15:0] px, logic signed [15:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1; coord_x_i <= px; coord_y_i <= py;
    pending_results.push_back(sector_strength(px, py));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random point, mostly small radii so that narrow annuli get hits
  task automatic send_random(int n);
    logic signed [15:0] px, py;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        px = $urandom; py = $urandom;
      end else begin
        px = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
        py = $signed(16'($urandom_range(0, 8191))) - 16'sd4096;
      end
      send_point(px, py);
    end
  endtask

  // receiver stall and result check
  always @(negedge clk_i) begin
    if (hold_off_cycles != 0) begin
      out_stall_i <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    sector_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected transaction: inside %0b strength %0d",
                                          inside_res_o, strength_o);
      end else begin
        want = pending_results.pop_front();
        if (want.in_sector !== inside_res_o || want.strength !== strength_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected inside %0b strength %0d, got %0b %0d",
                     want.in_sector, want.strength, inside_res_o, strength_o);
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else if (rst_ni && pending_results.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic test_directed();
    set_sector(0, 65535, 0, 23040);
    send_point(0, 0);
    send_point(16'sh7FFF, 0);
    send_point(-16'sh8000, 0);
    send_point(0, 16'sh7FFF);
    send_point(0, -16'sh8000);
    send_point(-16'sh8000, -16'sh8000);
    send_point(16'sh7FFF, 16'sh7FFF);
    send_point(-1, -1);
    send_point(16'sh5555, -16'sh2AAB);
    send_point(-16'sh2AAB, 16'sh5555);
    // wrapped window and out-of-range angle registers
    set_sector(256, 1024, 20000, 2000);
    send_point(512, 10);
    send_point(512, -10);
    send_point(0, 512);
    set_sector(0, 4096, 32767, 30000);
    send_point(300, 1);
    send_point(-300, 0);
    // zero ranges and empty radius window
    set_sector(512, 512, 5760, 5760);
    send_point(0, 512);
    send_point(512, 0);
    set_sector(1000, 200, 0, 23040);
    send_point(300, 300);
    send_point(0, 0);
  endtask

  task automatic test_random_phases();
    int settings[5][4] = '{'{0, 65535, 0, 23040}, '{128, 2048, 3000, 15000},
                           '{0, 1500, 18000, 4000}, '{65535, 65535, 23040, 0},
                           '{700, 700, 100, 100}};
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 77 : 0;
      recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 22 : 0;
      foreach (settings[k]) begin
        set_sector(settings[k][0], settings[k][1], settings[k][2], settings[k][3]);
        send_random(100);
      end
      set_sector($urandom, $urandom, $urandom_range(0, 32767), $urandom_range(0, 32767));
      send_random(90);
    end
  endtask

  // long receiver stall while points keep coming, then a full drain and a few more points
  task automatic test_backpressure();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_sector(0, 3000, 0, 23040);
    hold_off_cycles = 200;
    send_random(100);
    wait_drained();
    send_random(20);
  endtask

  initial begin
    mismatch_cnt = 0; idle_cycles = 0; hold_off_cycles = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    min_rad_q = 0; max_rad_q = 16'hFFFF; start_ang_q = 23040; end_ang_q = 23040;
    start_ang_q = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random_phases();
    test_backpressure();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
